// ----- rtl/core/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Task table size, operation, state and status codes, transfer payloads and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
    localparam int OP_W      = 3;
    localparam int SP_W      = 32;
    localparam int TASK_W    = 4;
    localparam int SLEEP_W   = 32;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_SLEEP    = 3'd2,
        OP_TICK     = 3'd3,
        OP_SET_IDLE = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_IDLE    = 2'd3
    } task_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NO_TASKS = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_ACCEPT = 2'd0,
        RES_SCHED  = 2'd1,
        RES_PLAIN  = 2'd2
    } res_sel_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCHED_CHECK,
        CS_SCAN,
        CS_PICK,
        CS_SCHED_OUT,
        CS_TICK
    } ctrl_state_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SP_W-1:0]    stack_pointer;
        logic [TASK_W-1:0]  task_index;
        logic [SLEEP_W-1:0] sleep_count;
    } req_item_t;

    typedef struct packed {
        logic [SP_W-1:0]     stack_pointer_out;
        logic [TASK_W-1:0]   task_index_out;
        logic [STATUS_W-1:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic     create;
        logic     sched_save;
        logic     sleep;
        logic     set_idle;
        logic     tick_start;
        logic     sched_start;
        logic     scan_step;
        logic     tick_step;
        logic     pick;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic index_bad;
        logic walk_busy;
    } dp_stat_t;

endpackage

// ----- rtl/core/round_robin_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: hardware round-robin task scheduler
// Create, schedule, sleep, tick and set-idle over a ring of up to MAX_TASKS.
// Create, sleep, set idle, unknown ops and empty-table cases are answered from the idle state.
// Schedule: check, scan, pick and output states; the one-entry-a-cycle state scan stops at the first ready task.
// Tick: a sweep over every entry of the state/count memories.
// One request in flight; the next is taken once the result is registered.
// Reset clears task count, current task and sequencer; memories need no clear.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    rsp_item_t result;
    logic      rsp_load;
    logic      rsp_free;

    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;

    // The response register is free when empty or being drained this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    rrts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_op    (req_item.op),
        .rsp_free  (rsp_free),
        .stat      (stat),
        .cmd       (cmd),
        .rsp_load  (rsp_load)
    );

    rrts_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_item_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ----- rtl/core/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrts_ctrl: operation sequencer
// Accepts one request at a time and steps the datapath through schedule
// scans and tick sweeps; loads the response register when a result is ready.
// ----------------------------------------------------------------------------
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic [OP_W-1:0] req_op,
    input  logic            rsp_free,
    input  dp_stat_t        stat,
    output dp_cmd_t         cmd,
    output logic            rsp_load
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_ACCEPT;
        rsp_load   = 1'b0;
        req_stall  = 1'b1;
        case (state_reg)
            CS_IDLE:
            begin
                req_stall = !rsp_free;
                if (req_valid && rsp_free)
                begin
                    case (req_op)
                        OP_CREATE:
                        begin
                            cmd.create = !stat.count_full;
                            rsp_load   = 1'b1;
                        end
                        OP_SCHEDULE:
                        begin
                            if (stat.count_zero)
                            begin
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                cmd.sched_save = 1'b1;
                                state_next     = CS_SCHED_CHECK;
                            end
                        end
                        OP_SLEEP:
                        begin
                            cmd.sleep = !stat.count_zero;
                            rsp_load  = 1'b1;
                        end
                        OP_TICK:
                        begin
                            if (stat.count_zero)
                            begin
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                cmd.tick_start = 1'b1;
                                state_next     = CS_TICK;
                            end
                        end
                        OP_SET_IDLE:
                        begin
                            cmd.set_idle = !stat.index_bad;
                            rsp_load     = 1'b1;
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            CS_SCHED_CHECK:
            begin
                cmd.sched_start = 1'b1;
                state_next      = CS_SCAN;
            end
            CS_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (!stat.walk_busy)
                begin
                    state_next = CS_PICK;
                end
            end
            CS_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = CS_SCHED_OUT;
            end
            CS_SCHED_OUT:
            begin
                cmd.res_sel = RES_SCHED;
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            CS_TICK:
            begin
                cmd.tick_step = 1'b1;
                cmd.res_sel   = RES_PLAIN;
                if (!stat.walk_busy && rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rrts_datapath.sv -----
// ----------------------------------------------------------------------------
// rrts_datapath: task table and scan logic
// Holds task count, current task and the state, sleep and stack pointer
// memories; walks the ring one entry a cycle for scans and tick sweeps.
// ----------------------------------------------------------------------------
module rrts_datapath
    import rrts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output rsp_item_t result
);

    // Table memories
    logic [1:0]         st_mem_reg  [MAX_TASKS];
    logic [SLEEP_W-1:0] cnt_mem_reg [MAX_TASKS];
    logic [SP_W-1:0]    sp_mem_reg  [MAX_TASKS];
    logic [1:0]         st_rdata_reg;
    logic [SLEEP_W-1:0] cnt_rdata_reg;
    logic [SP_W-1:0]    sp_rdata_reg;

    logic [COUNT_W-1:0] task_count_reg;
    logic [IDX_W-1:0]   current_task_reg;

    // Walk control
    logic [IDX_W-1:0]   iss_addr_reg;
    logic [COUNT_W-1:0] iss_left_reg;
    logic               pend_valid_reg;
    logic [IDX_W-1:0]   pend_addr_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_addr_reg;
    logic               idle_seen_reg;
    logic [IDX_W-1:0]   idle_addr_reg;
    logic               cur_ready_reg;

    logic               issue;
    logic [IDX_W-1:0]   cnt_idx;
    logic [IDX_W-1:0]   req_idx;
    logic [IDX_W-1:0]   chosen;
    logic               tick_hit;

    logic               st_we;
    logic [IDX_W-1:0]   st_waddr;
    logic [1:0]         st_wdata;
    logic               st_re;
    logic [IDX_W-1:0]   st_raddr;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr;
    logic [SLEEP_W-1:0] cnt_wdata;
    logic               sp_we;
    logic [IDX_W-1:0]   sp_waddr;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(idx) + COUNT_W'(1);
        return (n >= count) ? '0 : n[IDX_W-1:0];
    endfunction

    assign cnt_idx = task_count_reg[IDX_W-1:0];
    assign req_idx = IDX_W'(req.task_index);

    assign stat.count_zero = (task_count_reg == '0);
    assign stat.count_full = (task_count_reg >= COUNT_W'(MAX_TASKS));
    assign stat.index_bad  = (COUNT_W'(req.task_index) >= task_count_reg);
    assign stat.walk_busy  = ((iss_left_reg != '0) && !found_reg) || pend_valid_reg;

    assign issue = ((cmd.scan_step && !found_reg) || cmd.tick_step) && (iss_left_reg != '0);

    // Blocked task with a live count; ready it when the count runs out
    assign tick_hit = cmd.tick_step && pend_valid_reg && (st_rdata_reg == ST_BLOCKED)
                      && (cnt_rdata_reg != '0);

    always_comb
    begin
        if (found_reg)
        begin
            chosen = found_addr_reg;
        end
        else if (cur_ready_reg)
        begin
            chosen = current_task_reg;
        end
        else if (idle_seen_reg)
        begin
            chosen = idle_addr_reg;
        end
        else
        begin
            chosen = current_task_reg;
        end
    end

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = current_task_reg;
        st_wdata = ST_READY;
        if (cmd.create)
        begin
            st_we    = 1'b1;
            st_waddr = cnt_idx;
            st_wdata = ST_READY;
        end
        else if (cmd.sleep)
        begin
            st_we    = 1'b1;
            st_wdata = ST_BLOCKED;
        end
        else if (cmd.set_idle)
        begin
            st_we    = 1'b1;
            st_waddr = req_idx;
            st_wdata = ST_IDLE;
        end
        else if (cmd.sched_start)
        begin
            st_we    = (st_rdata_reg == ST_RUNNING);
            st_wdata = ST_READY;
        end
        else if (cmd.pick)
        begin
            st_we    = 1'b1;
            st_waddr = chosen;
            st_wdata = ST_RUNNING;
        end
        else if (tick_hit)
        begin
            st_we    = (cnt_rdata_reg == SLEEP_W'(1));
            st_waddr = pend_addr_reg;
            st_wdata = ST_READY;
        end
    end

    assign st_re    = cmd.sched_save || issue;
    assign st_raddr = cmd.sched_save ? current_task_reg : iss_addr_reg;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = current_task_reg;
        cnt_wdata = '0;
        if (cmd.create)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = cnt_idx;
        end
        else if (cmd.sleep)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = req.sleep_count;
        end
        else if (tick_hit)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = pend_addr_reg;
            cnt_wdata = cnt_rdata_reg - SLEEP_W'(1);
        end
    end

    assign sp_we    = cmd.create || cmd.sched_save;
    assign sp_waddr = cmd.create ? cnt_idx : current_task_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem_reg[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rdata_reg <= st_mem_reg[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem_reg[cnt_waddr] <= cnt_wdata;
        end
        if (issue && cmd.tick_step)
        begin
            cnt_rdata_reg <= cnt_mem_reg[iss_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_mem_reg[sp_waddr] <= req.stack_pointer;
        end
        if (cmd.pick)
        begin
            sp_rdata_reg <= sp_mem_reg[chosen];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg   <= '0;
            current_task_reg <= '0;
            iss_addr_reg     <= '0;
            iss_left_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            found_reg        <= 1'b0;
            idle_seen_reg    <= 1'b0;
            cur_ready_reg    <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= issue;
            if (cmd.create)
            begin
                task_count_reg <= task_count_reg + COUNT_W'(1);
            end
            if (cmd.pick)
            begin
                current_task_reg <= chosen;
            end
            if (cmd.sched_start)
            begin
                iss_addr_reg  <= ring_next(current_task_reg, task_count_reg);
                iss_left_reg  <= task_count_reg - COUNT_W'(1);
                found_reg     <= 1'b0;
                idle_seen_reg <= 1'b0;
                cur_ready_reg <= (st_rdata_reg == ST_RUNNING) || (st_rdata_reg == ST_READY);
            end
            else if (cmd.tick_start)
            begin
                iss_addr_reg <= '0;
                iss_left_reg <= task_count_reg;
                found_reg    <= 1'b0;
            end
            else if (issue)
            begin
                iss_addr_reg <= ring_next(iss_addr_reg, task_count_reg);
                iss_left_reg <= iss_left_reg - COUNT_W'(1);
            end
            // Keep the first ready task; remember the last idle one seen
            if (cmd.scan_step && pend_valid_reg && !found_reg)
            begin
                if (st_rdata_reg == ST_READY)
                begin
                    found_reg <= 1'b1;
                end
                else if (st_rdata_reg == ST_IDLE)
                begin
                    idle_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_addr_reg <= iss_addr_reg;
        end
        if (cmd.scan_step && pend_valid_reg && !found_reg)
        begin
            if (st_rdata_reg == ST_READY)
            begin
                found_addr_reg <= pend_addr_reg;
            end
            else if (st_rdata_reg == ST_IDLE)
            begin
                idle_addr_reg <= pend_addr_reg;
            end
        end
    end

    always_comb
    begin
        result.stack_pointer_out = '0;
        result.task_index_out    = TASK_W'(current_task_reg);
        result.status            = STATUS_OK;
        case (cmd.res_sel)
            RES_ACCEPT:
            begin
                case (req.op)
                    OP_CREATE:
                    begin
                        if (stat.count_full)
                        begin
                            result.status = STATUS_FULL;
                        end
                        else
                        begin
                            result.task_index_out = TASK_W'(task_count_reg);
                        end
                    end
                    OP_SCHEDULE:
                    begin
                        if (stat.count_zero)
                        begin
                            result.stack_pointer_out = req.stack_pointer;
                            result.status            = STATUS_NO_TASKS;
                        end
                    end
                    OP_SLEEP, OP_TICK:
                    begin
                        if (stat.count_zero)
                        begin
                            result.status = STATUS_NO_TASKS;
                        end
                    end
                    OP_SET_IDLE:
                    begin
                        if (stat.index_bad)
                        begin
                            result.status = STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        result.status = STATUS_OK;
                    end
                endcase
            end
            RES_SCHED:
            begin
                result.stack_pointer_out = sp_rdata_reg;
            end
            default:
            begin
                result.status = STATUS_OK;
            end
        endcase
    end

endmodule
